// ----- design/skl_pkg.sv -----
// ----------------------------------------------------------------------------
// skl_pkg
// shared types, codes and constants for the sorted key list unit
// ----------------------------------------------------------------------------
package skl_pkg;

    localparam int unsigned DEFAULT_CAPACITY = 16;
    localparam int unsigned KEY_W            = 32;
    localparam int unsigned COUNT_FIELD_W    = 5;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // input beat
    typedef struct packed {
        logic [0:0] command;
        t_key       key;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [1:0]               status;
        logic [COUNT_FIELD_W-1:0] count_after;
        t_key                     smallest_key;
        logic                     store_empty;
    } t_out_beat;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic ins_en;
        logic del_en;
        t_key key;
    } t_cell_ctl;

    // compare flags one cell hands to the next cell down the row
    typedef struct packed {
        logic ge;
        logic seen;
    } t_cell_flags;

endpackage

// ----- design/skl_cell.sv -----
// ----------------------------------------------------------------------------
// skl_cell
// one slot of the sorted row: compares, then keeps, loads or shifts its key
// ----------------------------------------------------------------------------
module skl_cell
    import skl_pkg::*;
(
    input  logic        i_clk,
    input  t_cell_ctl   i_ctl,
    input  logic        i_occupied,
    input  t_key        i_prev_key,
    input  t_cell_flags i_prev_flags,
    input  t_key        i_next_key,
    output t_key        o_key,
    output t_key        o_key_next,
    output t_cell_flags o_flags
);

    t_key r_key;
    t_key n_key;
    logic w_ge;
    logic w_lt;
    logic w_match;

    // empty slots count as larger than any key so an insert lands there
    assign w_ge    = !i_occupied || (r_key > i_ctl.key);
    assign w_lt    = i_occupied && (r_key < i_ctl.key);
    assign w_match = i_occupied && (r_key == i_ctl.key);

    assign o_flags.ge   = w_ge;
    assign o_flags.seen = i_prev_flags.seen | w_match;

    always_comb begin
        n_key = r_key;
        if (i_ctl.ins_en && w_ge) begin
            n_key = i_prev_flags.ge ? i_prev_key : i_ctl.key;
        end else if (i_ctl.del_en && !w_lt) begin
            n_key = i_next_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key      = r_key;
    assign o_key_next = n_key;

endmodule

// ----- design/sorted_key_list_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_key_list_unit
// bounded store of signed keys held in ascending order in a row of cells
// ----------------------------------------------------------------------------
// The unit takes one insert or delete beat per clock unless the result side
// is stalling, and returns one result beat for each, registered in the cycle
// after acceptance. Keys live in a row of CAPACITY cells, lowest key in cell
// 0; every cell compares its key with the command key in the same cycle and
// either keeps it, loads the new key, or takes its neighbor's key, so the
// whole row shifts in one step. The rate is set by that step and by the match
// flag that ripples down the row for a delete. A result waiting in the output
// register does not hold up a new command unless the result side is stalling.
// Status: done, delete found no equal key, or insert refused when full.
// ----------------------------------------------------------------------------
module sorted_key_list_unit
    import skl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // output register and fill count
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_beat        r_out_beat;
    t_out_beat        n_out_beat;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW+COUNT_FIELD_W-1:0] w_count_ext;

    logic             w_accept;
    logic             w_is_insert;
    logic             w_full;
    logic             w_found;
    t_cell_ctl        w_ctl;

    // cell row wiring
    t_key             w_key      [CAPACITY];
    t_key             w_key_next [CAPACITY];
    t_cell_flags      w_flags    [CAPACITY];

    // a new beat can come in unless the result side holds a stalled beat
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_is_insert = (i_in_beat.command == CMD_INSERT);
    assign w_full      = (r_count == CW'(CAPACITY));
    // last cell sees every match up the row
    assign w_found     = w_flags[CAPACITY-1].seen;

    assign w_ctl.ins_en = w_accept && w_is_insert && !w_full;
    assign w_ctl.del_en = w_accept && !w_is_insert && w_found;
    assign w_ctl.key    = i_in_beat.key;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_key        w_prev_key;
            t_cell_flags w_prev_flags;
            t_key        w_next_key;

            if (gi == 0) begin : g_head
                // head cell: nothing ahead, always the insert point when ge
                assign w_prev_key   = '0;
                assign w_prev_flags = '0;
            end else begin : g_body
                assign w_prev_key   = w_key[gi-1];
                assign w_prev_flags = w_flags[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                // tail slot becomes free on a delete; its value is don't-care
                assign w_next_key = w_key[gi];
            end else begin : g_mid
                assign w_next_key = w_key[gi+1];
            end

            skl_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (CW'(gi) < r_count),
                .i_prev_key   (w_prev_key),
                .i_prev_flags (w_prev_flags),
                .i_next_key   (w_next_key),
                .o_key        (w_key[gi]),
                .o_key_next   (w_key_next[gi]),
                .o_flags      (w_flags[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.ins_en) begin
            n_count = r_count + CW'(1);
        end else if (w_ctl.del_en) begin
            n_count = r_count - CW'(1);
        end
    end

    // count field carries only its low bits
    assign w_count_ext = {{COUNT_FIELD_W{1'b0}}, n_count};

    always_comb begin
        n_out_beat = r_out_beat;
        if (w_accept) begin
            if (w_is_insert) begin
                n_out_beat.status = w_full ? ST_FULL : ST_DONE;
            end else begin
                n_out_beat.status = w_found ? ST_DONE : ST_NOT_FOUND;
            end
            n_out_beat.count_after  = w_count_ext[COUNT_FIELD_W-1:0];
            n_out_beat.store_empty  = (n_count == '0);
            n_out_beat.smallest_key = (n_count == '0) ? '0 : w_key_next[0];
        end
    end

    always_comb begin
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ----- design/skl_checker.sv -----
// ----------------------------------------------------------------------------
// skl_checker
// port-level checks for the sorted key list unit
// ----------------------------------------------------------------------------
module skl_checker
    import skl_pkg::*;
#(
    parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_beat,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_beat
);

    localparam logic [COUNT_FIELD_W-1:0] CAP_FIELD = COUNT_FIELD_W'(CAPACITY);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_beat))
        else $error("result beat changed under stall");

    // every accepted command produces a result in the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("no result after accepted beat");

    // empty flag, head key and status agree
    a_empty_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.store_empty |->
            o_out_beat.smallest_key == '0 && o_out_beat.status != ST_FULL)
        else $error("empty store reports a key or full");

    // a refused insert only happens at full capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.status == ST_FULL |->
            o_out_beat.count_after == CAP_FIELD && !o_out_beat.store_empty)
        else $error("full status with wrong count");

endmodule

bind sorted_key_list_unit skl_checker #(
    .CAPACITY (CAPACITY)
) u_skl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_beat   (i_in_beat),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);
